// File: hw/rtl/bslp_pkg.sv
// ----------------------------------------------------------------------------
// bslp_pkg
// Shared types and constants for the button short/long press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bslp_pkg;

  // Register widths and indexes
  localparam int unsigned IntervalW = 8;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned EventW    = 2;
  localparam int unsigned TdataW    = 8;

  localparam logic [CfgIdxW-1:0] RegSampleInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] RegConfirmTicks   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLongExtraTicks = 2'd2;

  // Reset values of the registers
  localparam logic [IntervalW-1:0] SampleIntervalRst = 8'd10;
  localparam logic [TicksW-1:0]    ConfirmTicksRst   = 16'd100;
  localparam logic [TicksW-1:0]    LongExtraTicksRst = 16'd2900;

  // Event codes
  localparam logic [EventW-1:0] EvNone  = 2'd0;
  localparam logic [EventW-1:0] EvShort = 2'd1;
  localparam logic [EventW-1:0] EvLong  = 2'd2;

  // Press phases, one-hot
  typedef enum logic [4:0] {
    PhIdle    = 5'b00001,
    PhConfirm = 5'b00010,
    PhHold    = 5'b00100,
    PhWaitLng = 5'b01000,
    PhWaitOff = 5'b10000
  } phase_e;

  // Configuration bundle
  typedef struct packed {
    logic [IntervalW-1:0] sample_interval;
    logic [TicksW-1:0]    confirm_ticks;
    logic [TicksW-1:0]    long_extra_ticks;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic power_on;
    logic key_level;
  } item_t;

endpackage

`default_nettype wire

// File: hw/rtl/bslp_cfg_regs.sv
// ----------------------------------------------------------------------------
// bslp_cfg_regs
// Configuration register file; write-only, indexes beyond the list ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module bslp_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bslp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bslp_pkg::CfgDataW-1:0]   cfg_data_i,
  output bslp_pkg::cfg_t                       cfg_o
);
  import bslp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSampleInterval: cfg_d.sample_interval  = cfg_data_i[IntervalW-1:0];
        RegConfirmTicks:   cfg_d.confirm_ticks    = cfg_data_i[TicksW-1:0];
        RegLongExtraTicks: cfg_d.long_extra_ticks = cfg_data_i[TicksW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_interval  <= SampleIntervalRst;
      cfg_q.confirm_ticks    <= ConfirmTicksRst;
      cfg_q.long_extra_ticks <= LongExtraTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/bslp_core.sv
// ----------------------------------------------------------------------------
// bslp_core
// Per-tick state update: sample divider, hold timer and press phase machine.
// ----------------------------------------------------------------------------
`default_nettype none

module bslp_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire bslp_pkg::item_t               item_i,
  input  wire bslp_pkg::cfg_t                cfg_i,
  output logic [bslp_pkg::EventW-1:0]        event_o
);
  import bslp_pkg::*;

  phase_e               phase_q, phase_d;
  logic [TicksW-1:0]    hold_q, hold_d;
  logic [IntervalW-1:0] div_q, div_d;
  logic                 level_q, level_d;
  logic [TicksW-1:0]    hold_inc;
  logic [IntervalW-1:0] div_inc;
  logic                 sample;

  // Saturating tick counters, then latch the level when the divider expires
  always_comb begin
    div_inc  = (div_q == '1) ? div_q : div_q + 1'b1;
    hold_inc = (hold_q == '1) ? hold_q : hold_q + 1'b1;
    sample   = (div_inc >= cfg_i.sample_interval);
    div_d    = sample ? '0 : div_inc;
    level_d  = sample ? item_i.key_level : level_q;
  end

  // Phase machine on the freshly latched level
  always_comb begin
    phase_d = phase_q;
    hold_d  = hold_inc;
    event_o = EvNone;
    unique case (phase_q)
      PhIdle: begin
        if (level_d) begin
          hold_d  = '0;
          phase_d = PhConfirm;
        end
      end
      PhConfirm: begin
        if (!level_d) begin
          phase_d = PhIdle;
        end else if (hold_inc >= cfg_i.confirm_ticks) begin
          hold_d = '0;
          if (item_i.power_on) begin
            phase_d = PhHold;
          end else begin
            event_o = EvShort;
            phase_d = PhWaitOff;
          end
        end
      end
      PhHold: begin
        if (!level_d) begin
          event_o = EvShort;
          hold_d  = '0;
          phase_d = PhIdle;
        end else if (hold_inc >= cfg_i.long_extra_ticks) begin
          event_o = EvLong;
          hold_d  = '0;
          phase_d = PhWaitLng;
        end
      end
      PhWaitLng, PhWaitOff: begin
        if (!level_d) begin
          phase_d = PhIdle;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  // Advance state once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      hold_q  <= '0;
      div_q   <= '0;
      level_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
      div_q   <= div_d;
      level_q <= level_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/button_short_long_press_classifier.sv
// ----------------------------------------------------------------------------
// button_short_long_press_classifier
// Classifies timer ticks of a button into short and long presses.
// Pipeline: input register, then result register.
// Throughput: one item per cycle while results are taken; the tick update is
// a single pass of logic between the input register and the result register.
// Reset: asynchronous, active low; registers return to their reset values,
// phase idle, counters and the latched level cleared, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module button_short_long_press_classifier (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input items
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [bslp_pkg::TdataW-1:0]    s_axis_tdata,  // [0] key_level, [1] power_on
  // Result items
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [bslp_pkg::TdataW-1:0]         m_axis_tdata,  // [1:0] press_event
  // Configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [bslp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bslp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bslp_pkg::*;

  cfg_t              cfg;
  item_t             in_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic [EventW-1:0] out_event_q;
  logic [EventW-1:0] step_event;
  logic              advance;

  bslp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Move an item into the result register when that register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  bslp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_q),
    .cfg_i   (cfg),
    .event_o (step_event)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.key_level <= s_axis_tdata[0];
      in_q.power_on  <= s_axis_tdata[1];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_event_q <= step_event;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TdataW-EventW){1'b0}}, out_event_q};

endmodule

`default_nettype wire

// File: hw/rtl/bslp_checker.sv
// ----------------------------------------------------------------------------
// bslp_checker
// Port-level checks for the press classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bslp_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  input  wire logic                           s_axis_tready,
  input  wire logic [bslp_pkg::TdataW-1:0]    s_axis_tdata,
  input  wire logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic [bslp_pkg::TdataW-1:0]    m_axis_tdata
);
  import bslp_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // A valid result stands on the output after every accepted item
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("result missing after accepted item");

  // An empty result stage never blocks the input
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result stage");

  // Only defined event codes, padding bits zero
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == {{(TdataW-EventW){1'b0}}, EvNone}
                    || m_axis_tdata == {{(TdataW-EventW){1'b0}}, EvShort}
                    || m_axis_tdata == {{(TdataW-EventW){1'b0}}, EvLong}))
    else $error("bad event code on result");

endmodule

bind button_short_long_press_classifier bslp_checker u_bslp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button short/long press classifier. A queue of
// timer ticks feeds a stream driver with random gaps. A tick-accurate
// classifier model, run on every accepted tick, queues the expected press
// event. A monitor compares each accepted result with the oldest expected
// event. Phases cover the reset settings, small and zero thresholds and
// intervals, and a press that never confirms at the widest thresholds.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bslp_pkg::*;

  localparam int unsigned IdlePct    = 20;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TdataW-1:0] s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Pending ticks and expected press events
  item_t             tick_q[$];
  logic [EventW-1:0] press_exp_q[$];

  int unsigned cycle_cnt  = 0;
  int unsigned err_cnt    = 0;
  logic        drain_hold = 1'b0;
  wire         quiet      = (cycle_cnt % 4096) < 512;

  // Model copy of the registers and the classifier state
  logic [IntervalW-1:0] intv_cfg;
  logic [TicksW-1:0]    confirm_cfg;
  logic [TicksW-1:0]    long_cfg;
  phase_e               press_ph;
  logic [TicksW-1:0]    hold_cnt;
  logic [IntervalW-1:0] tick_div;
  logic                 latched_lvl;

  button_short_long_press_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance one tick of the classifier and queue its press event
  task automatic classify_tick(input item_t it);
    logic [EventW-1:0] ev;
    ev = EvNone;
    if (tick_div != 8'hFF) tick_div++;
    if (hold_cnt != 16'hFFFF) hold_cnt++;
    if (tick_div >= intv_cfg) begin
      tick_div    = '0;
      latched_lvl = it.key_level;
    end
    case (press_ph)
      PhIdle: begin
        if (latched_lvl) begin
          hold_cnt = '0;
          press_ph = PhConfirm;
        end
      end
      PhConfirm: begin
        if (!latched_lvl) begin
          press_ph = PhIdle;
        end else if (hold_cnt >= confirm_cfg) begin
          hold_cnt = '0;
          if (it.power_on) begin
            press_ph = PhHold;
          end else begin
            ev       = EvShort;
            press_ph = PhWaitOff;
          end
        end
      end
      PhHold: begin
        if (!latched_lvl) begin
          ev       = EvShort;
          hold_cnt = '0;
          press_ph = PhIdle;
        end else if (hold_cnt >= long_cfg) begin
          hold_cnt = '0;
          ev       = EvLong;
          press_ph = PhWaitLng;
        end
      end
      PhWaitLng, PhWaitOff: begin
        if (!latched_lvl) press_ph = PhIdle;
      end
      default: press_ph = PhIdle;
    endcase
    press_exp_q.push_back(ev);
  endtask

  // Write one register while the block is idle, mirroring it in the model
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      RegSampleInterval: intv_cfg    = data[IntervalW-1:0];
      RegConfirmTicks:   confirm_cfg = data[TicksW-1:0];
      RegLongExtraTicks: long_cfg    = data[TicksW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Queue n ticks of one button level and power state
  task automatic add_run(input logic lvl, input logic pw, input int n);
    item_t it;
    it.key_level = lvl;
    it.power_on  = pw;
    repeat (n) tick_q.push_back(it);
  endtask

  // Queue random presses sized around the current thresholds, plus some noise
  task automatic gen_presses(input int n);
    int   pushed, rel, len, mode, s, c, l, k;
    logic pw;
    item_t it;
    pushed = 0;
    s = (intv_cfg == 0) ? 1 : int'(intv_cfg);
    c = int'(confirm_cfg);
    l = int'(long_cfg);
    while (pushed < n) begin
      mode = $urandom_range(9);
      pw   = 1'($urandom_range(1));
      if (mode <= 7) begin
        rel = $urandom_range(2 * s + 3, 1);
        add_run(1'b0, pw, rel);
        case ($urandom_range(2))
          0:       len = $urandom_range(s + c + 2, 1);
          1:       len = $urandom_range(2 * s + c + l + 2, s + c);
          default: len = s + c + l + $urandom_range(2 * s + 4, 0);
        endcase
        // Flip power halfway through some presses
        if (mode == 7) begin
          add_run(1'b1, pw, len / 2 + 1);
          add_run(1'b1, !pw, len / 2 + 1);
        end else begin
          add_run(1'b1, pw, len);
        end
        pushed += rel + len;
      end else begin
        k = $urandom_range(12, 1);
        repeat (k) begin
          it.key_level = 1'($urandom_range(1));
          it.power_on  = 1'($urandom_range(1));
          tick_q.push_back(it);
        end
        pushed += k;
      end
    end
  endtask

  // Wait until every queued tick is accepted and every event has arrived
  task automatic wait_drained();
    while (tick_q.size() != 0 || s_axis_tvalid || press_exp_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Drain mid-phase once: hold the sender until every event is back
  task automatic pause_midway(input int half);
    while (tick_q.size() > half) @(posedge clk_i);
    drain_hold <= 1'b1;
    @(posedge clk_i);
    while (s_axis_tvalid || press_exp_q.size() != 0) @(posedge clk_i);
    drain_hold <= 1'b0;
  endtask

  // Tick driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_ticks
    item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tick_q.size() != 0 && !drain_hold && (quiet || $urandom_range(99) >= IdlePct)) begin
        nxt = tick_q.pop_front();
        s_axis_tdata  <= {{(TdataW - 2){1'b0}}, nxt};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= IdlePct);
    end
  end

  // Predict on accepted ticks, then check accepted results
  always @(posedge clk_i) begin : check_events
    logic [EventW-1:0] exp_ev;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) classify_tick(item_t'(s_axis_tdata[1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (press_exp_q.size() == 0) begin
          $display("%0t: unexpected result, actual press_event %0d", $time,
                   m_axis_tdata[EventW-1:0]);
          err_cnt++;
        end else begin
          exp_ev = press_exp_q.pop_front();
          if (m_axis_tdata[EventW-1:0] !== exp_ev) begin
            $display("%0t: press_event expected %0d, actual %0d", $time, exp_ev,
                     m_axis_tdata[EventW-1:0]);
            err_cnt++;
          end
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin : run_phases
    int s, c, l;
    intv_cfg    = SampleIntervalRst;
    confirm_cfg = ConfirmTicksRst;
    long_cfg    = LongExtraTicksRst;
    press_ph    = PhIdle;
    hold_cnt    = '0;
    tick_div    = '0;
    latched_lvl = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: short press with power on, then a power-off press
    add_run(1'b0, 1'b1, 10);
    add_run(1'b1, 1'b1, 125);
    add_run(1'b0, 1'b1, 15);
    add_run(1'b1, 1'b0, 120);
    add_run(1'b0, 1'b0, 15);
    wait_drained();

    // Directed presses with tight thresholds
    write_reg(RegSampleInterval, 16'd1);
    write_reg(RegConfirmTicks, 16'd2);
    write_reg(RegLongExtraTicks, 16'd3);
    add_run(1'b1, 1'b0, 6);
    add_run(1'b0, 1'b0, 2);
    add_run(1'b1, 1'b1, 4);
    add_run(1'b0, 1'b1, 2);
    add_run(1'b1, 1'b1, 9);
    add_run(1'b0, 1'b1, 2);
    add_run(1'b1, 1'b0, 2);
    add_run(1'b0, 1'b1, 1);
    add_run(1'b1, 1'b1, 1);
    add_run(1'b0, 1'b0, 1);
    wait_drained();

    // Zero interval and zero thresholds
    write_reg(RegSampleInterval, 16'd0);
    write_reg(RegConfirmTicks, 16'd0);
    write_reg(RegLongExtraTicks, 16'd0);
    gen_presses(100);
    wait_drained();

    // Random small settings
    for (int k = 0; k < 5; k++) begin
      s = (k == 0) ? 1 : $urandom_range(4, 1);
      c = (k == 3) ? 0 : $urandom_range(12);
      l = (k == 1) ? 0 : $urandom_range(25);
      write_reg(RegSampleInterval, {8'($urandom_range(255)), 8'(s)});
      write_reg(RegConfirmTicks, 16'(c));
      write_reg(RegLongExtraTicks, 16'(l));
      if (k == 2) write_reg(RegUnused, 16'($urandom_range(16'hFFFF)));
      gen_presses(75);
      if (k == 2) pause_midway(40);
      wait_drained();
    end

    // Widest thresholds: a press that never confirms, upper interval bits dropped
    write_reg(RegSampleInterval, 16'hA503);
    write_reg(RegConfirmTicks, 16'hFFFF);
    write_reg(RegLongExtraTicks, 16'hFFFF);
    add_run(1'b0, 1'b1, 10);
    add_run(1'b1, 1'b1, 50);
    add_run(1'b0, 1'b1, 10);
    wait_drained();

    if (err_cnt == 0 && press_exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
